// ===== design/b64lw_pkg.sv =====
package b64lw_pkg;

    // input beat: one raw byte and the end-of-stream flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_beat_t;

    // output beat: one character and the end-of-run flag
    typedef struct packed {
        logic [6:0] out_char;
        logic       run_end;
    } out_beat_t;

    localparam int GROUPS_PER_LINE_DEF = 15;
    localparam int MAX_CHARS           = 6;
    localparam int CNT_W               = $clog2(MAX_CHARS + 1);

    localparam logic [6:0] CHAR_CR      = 7'h0D;
    localparam logic [6:0] CHAR_LF      = 7'h0A;
    localparam logic [6:0] CHAR_PAD_STD = 7'h3D;  // '='
    localparam logic [6:0] CHAR_PAD_WEB = 7'h2D;  // '-'

    // one encoded group, first character in slot 0
    typedef struct packed {
        logic [MAX_CHARS-1:0][6:0] chars;
        logic [CNT_W-1:0]          count;
        logic                      fin;
    } group_t;

    // sender status seen by the group builder
    typedef struct packed {
        logic busy;
        logic last_taken;
    } snd_status_t;

    // six-bit value to alphabet character
    function automatic logic [6:0] enc_char(input logic [5:0] six, input logic web);
        logic [6:0] r;
        if (six < 6'd26) begin
            r = 7'h41 + 7'(six);
        end else if (six < 6'd52) begin
            r = 7'h61 + 7'(six - 6'd26);
        end else if (six < 6'd62) begin
            r = 7'h30 + 7'(six - 6'd52);
        end else if (six == 6'd62) begin
            r = web ? 7'h2E : 7'h2B;  // '.' or '+'
        end else begin
            r = web ? 7'h5F : 7'h2F;  // '_' or '/'
        end
        return r;
    endfunction

endpackage

// ===== design/b64lw_sender.sv =====
module b64lw_sender (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  b64lw_pkg::group_t     grp,
    output b64lw_pkg::snd_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output b64lw_pkg::out_beat_t  m_data
);
    import b64lw_pkg::*;

    logic [MAX_CHARS-1:0][6:0] chars_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic                      fin_reg;
    logic                      take;

    assign m_valid = (rem_reg != '0);
    assign take    = m_valid && m_ready;

    assign m_data.out_char = chars_reg[0];
    assign m_data.run_end  = fin_reg && (rem_reg == CNT_W'(1));

    assign status.busy       = m_valid;
    assign status.last_taken = take && (rem_reg == CNT_W'(1));

    // remaining character count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (load) begin
            rem_reg <= grp.count;
        end else if (take) begin
            rem_reg <= rem_reg - CNT_W'(1);
        end
    end

    // character shift line, slot 0 drives the output
    always_ff @(posedge aclk) begin
        if (load) begin
            chars_reg <= grp.chars;
            fin_reg   <= grp.fin;
        end else if (take) begin
            chars_reg <= {7'd0, chars_reg[MAX_CHARS-1:1]};
        end
    end

endmodule

// ===== design/base64_line_wrapped_encoder.sv =====
// Line-wrapped Base64 encoder.
// Input channel s_*: one byte per beat, final_byte marks the last byte of a run.
// Output channel m_*: one 7-bit ASCII character per beat; run_end marks the
// last character caused by a final byte.
// cfg_we/cfg_wdata write the alphabet select (0 standard '=', 1 web '-' pad);
// write only while idle.
// Every third byte, or a final byte, closes a group of four characters, plus
// CR LF after every GROUPS_PER_LINE groups of a run. A closing byte loads the
// character shift line; its first character is offered in the cycle after the
// byte is accepted, then one character per cycle while m_ready is high.
// Throughput: one byte per cycle into the holding registers; a group of four
// or six characters then leaves through the single character port, which
// bounds the sustained byte rate.
// A byte that only fills the group is taken even while characters wait.
// A closing byte waits until the shift line is empty or its last character
// is taken; a stalled receiver thus back-pressures after at most two more bytes.
// Reset (aresetn low, synchronous) empties the output, clears the group and
// line counters and selects the standard alphabet.
module base64_line_wrapped_encoder #(
    parameter int GROUPS_PER_LINE = b64lw_pkg::GROUPS_PER_LINE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  b64lw_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output b64lw_pkg::out_beat_t m_data
);
    import b64lw_pkg::*;

    localparam logic [3:0] LINE_LIMIT = 4'(GROUPS_PER_LINE);

    logic        web_reg;
    logic [1:0]  pos_reg, pos_next;
    logic [15:0] held_reg, held_next;
    logic [3:0]  gol_reg, gol_next;

    logic        accept, completes, load, crlf;
    logic [1:0]  pos_eff;
    logic [7:0]  b0, b1, b2;
    logic [3:0]  gol_inc;
    logic [6:0]  pad;
    group_t      grp;
    snd_status_t snd;

    // alphabet register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            web_reg <= 1'b0;
        end else if (cfg_we) begin
            web_reg <= cfg_wdata;
        end
    end

    // accept control
    always_comb begin
        pos_eff   = (pos_reg == 2'd3) ? 2'd2 : pos_reg;
        completes = s_data.final_byte || (pos_eff == 2'd2);
        s_ready   = !completes || !snd.busy || snd.last_taken;
        accept    = s_valid && s_ready;
        load      = accept && completes;
    end

    // group assembly
    always_comb begin
        b0 = held_reg[15:8];
        b1 = held_reg[7:0];
        b2 = s_data.data_byte;
        if (pos_eff == 2'd0) begin
            b0 = s_data.data_byte;
            b1 = 8'd0;
            b2 = 8'd0;
        end else if (pos_eff == 2'd1) begin
            b1 = s_data.data_byte;
            b2 = 8'd0;
        end
        pad     = web_reg ? CHAR_PAD_WEB : CHAR_PAD_STD;
        gol_inc = gol_reg + 4'd1;
        crlf    = (gol_inc >= LINE_LIMIT) || (gol_inc == 4'd0);

        grp.chars[0] = enc_char(b0[7:2], web_reg);
        grp.chars[1] = enc_char({b0[1:0], b1[7:4]}, web_reg);
        grp.chars[2] = (pos_eff != 2'd0) ? enc_char({b1[3:0], b2[7:6]}, web_reg) : pad;
        grp.chars[3] = (pos_eff == 2'd2) ? enc_char(b2[5:0], web_reg) : pad;
        grp.chars[4] = CHAR_CR;
        grp.chars[5] = CHAR_LF;
        grp.count    = crlf ? CNT_W'(MAX_CHARS) : CNT_W'(4);
        grp.fin      = s_data.final_byte;
    end

    // next group and line state
    always_comb begin
        pos_next  = pos_reg;
        held_next = held_reg;
        gol_next  = gol_reg;
        if (accept) begin
            if (!completes) begin
                pos_next = pos_eff + 2'd1;
                if (pos_eff == 2'd0) begin
                    held_next = {s_data.data_byte, 8'd0};
                end else begin
                    held_next = {held_reg[15:8], s_data.data_byte};
                end
            end else begin
                pos_next  = 2'd0;
                held_next = 16'd0;
                gol_next  = (s_data.final_byte || crlf) ? 4'd0 : gol_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 2'd0;
            held_reg <= 16'd0;
            gol_reg  <= 4'd0;
        end else begin
            pos_reg  <= pos_next;
            held_reg <= held_next;
            gol_reg  <= gol_next;
        end
    end

    // character output
    b64lw_sender u_sender (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .grp     (grp),
        .status  (snd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // checks
    a_group_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("closed group not offered on output");

    a_empty_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == 2'd0) |-> (held_reg == 16'd0))
        else $error("bytes held in an empty group");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 2'd3)
        else $error("group position out of range");

    a_line_range: assert property (@(posedge aclk) disable iff (!aresetn)
        gol_reg < LINE_LIMIT)
        else $error("line group count past limit");

endmodule

// ===== tb/b64_char_monitor.sv =====
module b64_char_monitor
    import b64lw_pkg::*;
#(
    parameter int GROUPS_PER_LINE = GROUPS_PER_LINE_DEF,
    parameter int MAX_REPORTS     = 40
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_beat_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_beat_t m_data,
    output int        mismatches,
    output int        chars_pending,
    output int        chars_seen
);

    // alphabets, first symbol in the top byte
    localparam logic [8*64-1:0] STD_SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [8*64-1:0] WEB_SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789._";

    // own copy of the encoder state
    logic        web_sel;
    logic [1:0]  grp_pos;
    logic [15:0] held;
    logic [3:0]  line_groups;
    out_beat_t   exp_chars[$];
    int          err_total;
    int          seen_total;

    initial begin
        web_sel     = 1'b0;
        grp_pos     = '0;
        held        = '0;
        line_groups = '0;
        err_total   = 0;
        seen_total  = 0;
        mismatches    = 0;
        chars_pending = 0;
        chars_seen    = 0;
    end

    function automatic logic [6:0] b64_symbol(input logic [5:0] six, input logic web);
        logic [7:0] c;
        int         idx;
        idx = 63 - int'(six);
        c = web ? WEB_SYMBOLS[8*idx +: 8] : STD_SYMBOLS[8*idx +: 8];
        return c[6:0];
    endfunction

    always @(posedge aclk) begin : watch_proc
        logic [7:0] b0, b1, b2;
        logic [1:0] pos;
        logic [6:0] pad;
        logic [6:0] chars [0:5];
        logic       fin;
        int         n, cnt, k;
        out_beat_t  want;

        if (!aresetn) begin
            web_sel     = 1'b0;
            grp_pos     = '0;
            held        = '0;
            line_groups = '0;
            exp_chars.delete();
        end else begin
            // compare each delivered character with the oldest expectation
            if (m_valid && m_ready) begin
                seen_total++;
                if (exp_chars.size() == 0) begin
                    err_total++;
                    if (err_total <= MAX_REPORTS)
                        $display("%0t: stray beat: expected none, actual char %h run_end %b",
                                 $time, m_data.out_char, m_data.run_end);
                end else begin
                    want = exp_chars.pop_front();
                    if (m_data.out_char !== want.out_char) begin
                        err_total++;
                        if (err_total <= MAX_REPORTS)
                            $display("%0t: out_char mismatch: expected %h, actual %h",
                                     $time, want.out_char, m_data.out_char);
                    end
                    if (m_data.run_end !== want.run_end) begin
                        err_total++;
                        if (err_total <= MAX_REPORTS)
                            $display("%0t: run_end mismatch: expected %b, actual %b",
                                     $time, want.run_end, m_data.run_end);
                    end
                end
            end

            // predict the characters caused by an accepted byte
            if (s_valid && s_ready) begin
                fin = s_data.final_byte;
                pos = (grp_pos > 2'd2) ? 2'd2 : grp_pos;
                if (!fin && pos < 2'd2) begin
                    // byte only joins the group
                    if (pos == 2'd0)
                        held = {s_data.data_byte, 8'h00};
                    else
                        held[7:0] = s_data.data_byte;
                    grp_pos = pos + 2'd1;
                end else begin
                    n  = int'(pos) + 1;
                    b0 = (n == 1) ? s_data.data_byte : held[15:8];
                    b1 = (n == 1) ? 8'h00 : ((n == 2) ? s_data.data_byte : held[7:0]);
                    b2 = (n == 3) ? s_data.data_byte : 8'h00;
                    pad = web_sel ? CHAR_PAD_WEB : CHAR_PAD_STD;
                    chars[0] = b64_symbol(b0[7:2], web_sel);
                    chars[1] = b64_symbol({b0[1:0], b1[7:4]}, web_sel);
                    chars[2] = (n > 1) ? b64_symbol({b1[3:0], b2[7:6]}, web_sel) : pad;
                    chars[3] = (n > 2) ? b64_symbol(b2[5:0], web_sel) : pad;
                    cnt = 4;
                    // line break after a full line of groups
                    line_groups = line_groups + 4'd1;
                    if (line_groups >= GROUPS_PER_LINE || line_groups == 4'd0) begin
                        line_groups = '0;
                        chars[4] = CHAR_CR;
                        chars[5] = CHAR_LF;
                        cnt = 6;
                    end
                    grp_pos = '0;
                    held    = '0;
                    if (fin)
                        line_groups = '0;
                    for (k = 0; k < cnt; k++) begin
                        want.out_char = chars[k];
                        want.run_end  = fin && (k == cnt - 1);
                        exp_chars.push_back(want);
                    end
                end
            end

            if (cfg_we)
                web_sel = cfg_wdata;
        end

        mismatches    <= err_total;
        chars_pending <= exp_chars.size();
        chars_seen    <= seen_total;
    end

endmodule

// ===== tb/tb_base64_line_wrapped_encoder.sv =====
module tb_base64_line_wrapped_encoder;
    import b64lw_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_BYTES   = 98;
    localparam int PAUSE_AT_BYTE = 250;

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic      cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    logic quiet;
    logic hold_req;
    int   mismatches;
    int   chars_pending;
    int   chars_seen;
    int   cycles;
    int   bytes_sent;
    int   runs_sent;
    int   cfg_writes;

    // clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    base64_line_wrapped_encoder #(
        .GROUPS_PER_LINE(GROUPS_PER_LINE_DEF)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    b64_char_monitor #(
        .GROUPS_PER_LINE(GROUPS_PER_LINE_DEF)
    ) u_char_monitor (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .mismatches   (mismatches),
        .chars_pending(chars_pending),
        .chars_seen   (chars_seen)
    );

    // run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d characters still expected",
                 cycles, chars_pending);
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stalls, one long hold-off
    initial begin : char_sink
        logic held_off;
        held_off = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held_off) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // offer one byte after an optional gap and wait for its beat
    task automatic send_byte(input logic [7:0] value, input logic last, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {value, last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        if (last)
            runs_sent++;
    endtask

    // stop offering and wait until every expected character is out
    task automatic drain_chars;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (chars_pending != 0) @(posedge aclk);
    endtask

    task automatic set_alphabet(input logic web);
        drain_chars();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= web;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // mostly short runs, some that fill whole lines or end exactly on one
    function automatic int pick_run_length();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 4)
            return $urandom_range(1, 8);
        if (kind < 6)
            return $urandom_range(9, 40);
        if (kind < 8)
            return 3 * GROUPS_PER_LINE_DEF * $urandom_range(1, 2);
        return $urandom_range(43, 50);
    endfunction

    task automatic send_run(input int len);
        int         k;
        int         gap;
        logic [7:0] value;
        for (k = 0; k < len; k++) begin
            if (bytes_sent == PAUSE_AT_BYTE)
                drain_chars();
            if ($urandom_range(0, 7) == 0)
                value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                value = 8'($urandom_range(0, 255));
            gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            send_byte(value, k == len - 1, gap);
        end
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int phase;
        int budget;
        int run_len;
        aresetn    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= 1'b0;
        s_valid    <= 1'b0;
        s_data     <= '0;
        quiet      <= 1'b0;
        hold_req   <= 1'b0;
        bytes_sent = 0;
        runs_sent  = 0;
        cfg_writes = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: one, two and three byte groups, top symbols, zero and all-ones
        for (int w = 0; w < 2; w++) begin
            set_alphabet(w[0]);
            send_byte(8'h00, 1'b1, 0);
            send_byte(8'hFF, 1'b0, 0);
            send_byte(8'hFF, 1'b1, 0);
            send_byte(8'hFB, 1'b0, 0);
            send_byte(8'hFF, 1'b0, 0);
            send_byte(8'hBF, 1'b1, 0);
            send_byte(8'hFF, 1'b1, 0);
            send_byte(8'h00, 1'b0, 0);
            send_byte(8'h00, 1'b0, 0);
            send_byte(8'h00, 1'b1, 0);
        end

        // random runs under several alphabet settings, last run cut to the budget
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES - 1)
                quiet <= 1'b1;
            set_alphabet(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
            if (phase == 1)
                hold_req <= 1'b1;
            budget = bytes_sent + PHASE_BYTES;
            while (bytes_sent < budget) begin
                run_len = pick_run_length();
                if (run_len > budget - bytes_sent)
                    run_len = budget - bytes_sent;
                send_run(run_len);
            end
        end

        drain_chars();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("encoded %0d bytes in %0d runs under %0d alphabet writes",
                 bytes_sent, runs_sent, cfg_writes);
        $display("checked %0d characters, %0d mismatches, %0d left unmatched",
                 chars_seen, mismatches, chars_pending);
        if (mismatches == 0 && chars_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
